FILE: hdl/ou_noise_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ou_noise_pkg
// Types, constants and helper functions for the Ornstein-Uhlenbeck noise core.
// ----------------------------------------------------------------------------
package ou_noise_pkg;

	// Generator state geometry.
	localparam int MT_WORDS = 624;
	localparam int MT_AW    = 10;
	localparam logic [MT_AW-1:0] MT_LAST  = MT_AW'(MT_WORDS - 1);
	localparam logic [MT_AW-1:0] MT_SHIFT = MT_AW'(397);
	localparam logic [MT_AW-1:0] MT_WRAP  = MT_AW'(MT_WORDS - 397);
	localparam logic [31:0] MT_MATRIX    = 32'h9908_b0df;
	localparam logic [31:0] MT_SEED_MULT = 32'd1812433253;
	localparam logic [31:0] MT_TEMPER_B  = 32'h9d2c_5680;
	localparam logic [31:0] MT_TEMPER_C  = 32'hefc6_0000;

	// Deviate constants, Q.24 unless noted; P_FLOOR is scaled by 2^32.
	localparam logic [31:0] P_FLOOR   = 32'd4295;
	localparam logic [31:0] LN2X2_Q30 = 32'd1488522236;
	localparam logic [31:0] C0 = 32'd42203372;
	localparam logic [31:0] C1 = 32'd13469638;
	localparam logic [31:0] C2 = 32'd173275;
	localparam logic [31:0] D0 = 32'd24038194;
	localparam logic [31:0] D1 = 32'd3175407;
	localparam logic [31:0] D2 = 32'd21945;
	localparam logic [31:0] ONE_Q24 = 32'd16777216;

	// Register indexes.
	localparam logic [2:0] REG_THETA = 3'd0;
	localparam logic [2:0] REG_MEAN  = 3'd1;
	localparam logic [2:0] REG_SIGMA = 3'd2;
	localparam logic [2:0] REG_SEED  = 3'd3;
	localparam logic [2:0] REG_START = 3'd4;

	// Reset values of the registers.
	localparam logic [30:0] THETA_RST = 31'd65536;
	localparam logic [31:0] MEAN_RST  = 32'd0;
	localparam logic [30:0] SIGMA_RST = 31'd65536;
	localparam logic [31:0] SEED_RST  = 32'd5489;
	localparam logic [31:0] START_RST = 32'd0;

	// Input item kinds.
	localparam logic OP_EVAL = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	localparam int ACC_W = 96;

	typedef enum logic [5:0] {
		ST_SEED, ST_IDLE,
		ST_MT_RD0, ST_MT_RD1, ST_MT_RD2, ST_MT_WR,
		ST_NORM, ST_LOG_MUL, ST_LOG_ACC, ST_Y_MUL, ST_Y_SET, ST_SQRT,
		ST_N_MUL2, ST_N_ADD1, ST_N_MUL1, ST_N_ADD0,
		ST_D_MUL3, ST_D_ADD2, ST_D_MUL2, ST_D_ADD1, ST_D_MUL1, ST_D_ADD0,
		ST_DIV, ST_Z, ST_SDT_SET,
		ST_S_MUL, ST_S_SH, ST_NS_LO_MUL, ST_NS_LO, ST_NS_HI_MUL, ST_NS_HI,
		ST_DR_MUL, ST_DR_SH, ST_DL_MUL, ST_DL_LO, ST_DH_MUL, ST_DH_HI,
		ST_SUM, ST_DONE
	} state_t;

	// Output tempering of one generator word.
	function automatic logic [31:0] mt_temper(input logic [31:0] w);
		logic [31:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & MT_TEMPER_B);
		y = y ^ ((y << 15) & MT_TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	// Next word of the seeding recurrence.
	function automatic logic [31:0] mt_seed_next(input logic [31:0] w,
			input logic [MT_AW-1:0] idx);
		logic [63:0] pr;
		pr = {32'd0, MT_SEED_MULT} * {32'd0, w ^ (w >> 30)};
		return pr[31:0] + {22'd0, idx};
	endfunction

	// Limit a term to 2^40.
	function automatic logic [40:0] cap_term(input logic [ACC_W-1:0] v);
		logic [40:0] r;
		r = (|v[ACC_W-1:40]) ? {1'b1, 40'd0} : v[40:0];
		return r;
	endfunction

endpackage

FILE: hdl/ou_noise_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ou_noise_generator_core
// A load beat passes through the DONE state to the output register; an evaluate
// beat uses one shared multiplier, two 32-step square roots, a normalisation
// loop, a 24-step log loop and a 52-step divider.
// Throughput: one beat at a time; the next is taken when the core is idle.
// Reset: a seeding pass fills the 624-word generator memory before the first
// beat is taken; a seed write repeats that pass.
// ----------------------------------------------------------------------------
module ou_noise_generator_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,     // time_step[30:0], new_value[62:31], zero pad
	input  logic [0:0]  s_tuser,     // op[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,     // process_value[31:0]
	output logic [0:0]  m_tuser,     // saturated[0]
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_wr_data
);

	import ou_noise_pkg::*;

	state_t state_q, state_d;

	// Control and configuration registers.
	logic [30:0]      theta_q, sigma_q;
	logic [31:0]      mu_q, x_q;
	logic [MT_AW-1:0] pos_q, seed_idx_q;
	logic [31:0]      seed_word_q;
	logic             out_valid_q;
	logic [31:0]      res_val_q;
	logic             res_sat_q;
	logic             sat_q;

	// Datapath registers.
	logic [63:0]      prod_q;
	logic [31:0]      mt_w0_q, mt_w1_q;
	logic [31:0]      m_q;
	logic [4:0]       sh_q;
	logic [23:0]      f_q;
	logic [5:0]       cnt_q;
	logic             neg_q, zneg_q, diff_neg_q, sq_sel_q;
	logic [63:0]      sq_v_q, sq_res_q, sq_bit_q;
	logic [31:0]      t_q, sdt_q, tmp_q, den_q, rem_q, az_q, adiff_q;
	logic [27:0]      num_q;
	logic [51:0]      dq_q;
	logic [63:0]      s_q, a1_q;
	logic [ACC_W-1:0] acc_q;
	logic [40:0]      drift_q, noise_q;
	logic [30:0]      dt_q;

	// Memory signals.
	logic             ram_we;
	logic [MT_AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]      ram_wdata, ram_rdata;

	logic [31:0] mul_a, mul_b;

	ou_noise_ram #(
		.WIDTH (32),
		.DEPTH (MT_WORDS)
	) u_mt_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Generator addressing and the lazily twisted word.
	logic [MT_AW-1:0] pos_next, pos_far;
	logic [31:0]      mt_v, mt_new, mt_out, p_raw, p_clamped;
	assign pos_next  = (pos_q == MT_LAST) ? '0 : pos_q + MT_AW'(1);
	assign pos_far   = (pos_q >= MT_WRAP) ? pos_q - MT_WRAP : pos_q + MT_SHIFT;
	assign mt_v      = {mt_w0_q[31], mt_w1_q[30:0]};
	assign mt_new    = ram_rdata ^ {1'b0, mt_v[31:1]} ^ (mt_v[0] ? MT_MATRIX : 32'd0);
	assign mt_out    = mt_temper(mt_new);
	assign p_raw     = mt_out[31] ? ~mt_out : mt_out;
	assign p_clamped = (p_raw < P_FLOOR) ? P_FLOOR : p_raw;

	// Log loop and integer part of the log.
	logic [32:0] mm;
	logic [28:0] yq;
	assign mm = prod_q[63:31];
	assign yq = {5'(sh_q + 5'd1), 24'd0} - {5'd0, f_q};

	// One square-root step.
	logic [63:0] sq_trial, sq_v_next, sq_res_next;
	logic        sq_take;
	assign sq_trial    = sq_res_q + sq_bit_q;
	assign sq_take     = sq_v_q >= sq_trial;
	assign sq_v_next   = sq_take ? sq_v_q - sq_trial : sq_v_q;
	assign sq_res_next = sq_take ? (sq_res_q >> 1) + sq_bit_q : sq_res_q >> 1;

	// One divider step.
	logic [31:0] div_r;
	logic        div_ge;
	assign div_r  = {rem_q[30:0], dq_q[51]};
	assign div_ge = div_r >= den_q;

	// Signed deviate before its sign is applied.
	logic [32:0] z_raw;
	assign z_raw = {1'b0, t_q} - {1'b0, dq_q[31:0]};

	// Mean difference at the start of an evaluate beat.
	logic [32:0] diff;
	assign diff = {mu_q[31], mu_q} - {x_q[31], x_q};

	// Partial-product accumulation.
	logic [ACC_W-1:0] acc_sum;
	assign acc_sum = acc_q + {prod_q, 32'd0};

	// Final sum with saturation.
	logic [43:0] drift_s, noise_s, sum_w;
	logic [31:0] sum_val;
	logic        sum_sat;
	always_comb begin
		drift_s = diff_neg_q ? 44'd0 - {3'd0, drift_q} : {3'd0, drift_q};
		noise_s = zneg_q ? 44'd0 - {3'd0, noise_q} : {3'd0, noise_q};
		sum_w   = {{12{x_q[31]}}, x_q} + drift_s + noise_s;
		sum_sat = 1'b0;
		sum_val = sum_w[31:0];
		if (sum_w[43] && !(&sum_w[42:31])) begin
			sum_val = 32'h8000_0000;
			sum_sat = 1'b1;
		end else if (!sum_w[43] && (|sum_w[42:31])) begin
			sum_val = 32'h7fff_ffff;
			sum_sat = 1'b1;
		end
	end

	logic out_push, in_accept, seed_wr;
	assign in_accept = s_tvalid && (state_q == ST_IDLE);
	assign out_push  = (state_q == ST_DONE) && (!out_valid_q || m_tready);
	assign seed_wr   = cfg_wr_en && (cfg_addr == REG_SEED);

	// Memory port control.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = mt_new;
		ram_raddr = pos_q;
		case (state_q)
			ST_SEED: begin
				ram_we    = 1'b1;
				ram_waddr = seed_idx_q;
				ram_wdata = seed_word_q;
			end
			ST_MT_RD1: ram_raddr = pos_next;
			ST_MT_RD2: ram_raddr = pos_far;
			ST_MT_WR:  ram_we    = 1'b1;
			default: ;
		endcase
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_LOG_MUL: begin
				mul_a = m_q;
				mul_b = m_q;
			end
			ST_Y_MUL: begin
				mul_a = {3'd0, yq};
				mul_b = LN2X2_Q30;
			end
			ST_N_MUL2: begin
				mul_a = C2;
				mul_b = t_q;
			end
			ST_D_MUL3: begin
				mul_a = D2;
				mul_b = t_q;
			end
			ST_N_MUL1, ST_D_MUL2, ST_D_MUL1: begin
				mul_a = tmp_q;
				mul_b = t_q;
			end
			ST_S_MUL: begin
				mul_a = {1'b0, sigma_q};
				mul_b = sdt_q;
			end
			ST_NS_LO_MUL: begin
				mul_a = s_q[31:0];
				mul_b = az_q;
			end
			ST_NS_HI_MUL: begin
				mul_a = s_q[63:32];
				mul_b = az_q;
			end
			ST_DR_MUL: begin
				mul_a = {1'b0, theta_q};
				mul_b = adiff_q;
			end
			ST_DL_MUL: begin
				mul_a = a1_q[31:0];
				mul_b = {1'b0, dt_q};
			end
			ST_DH_MUL: begin
				mul_a = a1_q[63:32];
				mul_b = {1'b0, dt_q};
			end
			default: ;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SEED;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_SEED:      if (seed_idx_q == MT_LAST) state_d = ST_IDLE;
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = (s_tuser[0] == OP_LOAD) ? ST_DONE : ST_MT_RD0;
				end
			end
			ST_MT_RD0:    state_d = ST_MT_RD1;
			ST_MT_RD1:    state_d = ST_MT_RD2;
			ST_MT_RD2:    state_d = ST_MT_WR;
			ST_MT_WR:     state_d = ST_NORM;
			ST_NORM:      if (m_q[31]) state_d = ST_LOG_MUL;
			ST_LOG_MUL:   state_d = ST_LOG_ACC;
			ST_LOG_ACC:   state_d = (cnt_q == 6'd23) ? ST_Y_MUL : ST_LOG_MUL;
			ST_Y_MUL:     state_d = ST_Y_SET;
			ST_Y_SET:     state_d = ST_SQRT;
			ST_SQRT: begin
				if (sq_bit_q[0]) begin
					state_d = sq_sel_q ? ST_S_MUL : ST_N_MUL2;
				end
			end
			ST_N_MUL2:    state_d = ST_N_ADD1;
			ST_N_ADD1:    state_d = ST_N_MUL1;
			ST_N_MUL1:    state_d = ST_N_ADD0;
			ST_N_ADD0:    state_d = ST_D_MUL3;
			ST_D_MUL3:    state_d = ST_D_ADD2;
			ST_D_ADD2:    state_d = ST_D_MUL2;
			ST_D_MUL2:    state_d = ST_D_ADD1;
			ST_D_ADD1:    state_d = ST_D_MUL1;
			ST_D_MUL1:    state_d = ST_D_ADD0;
			ST_D_ADD0:    state_d = ST_DIV;
			ST_DIV:       if (cnt_q == 6'd51) state_d = ST_Z;
			ST_Z:         state_d = ST_SDT_SET;
			ST_SDT_SET:   state_d = ST_SQRT;
			ST_S_MUL:     state_d = ST_S_SH;
			ST_S_SH:      state_d = ST_NS_LO_MUL;
			ST_NS_LO_MUL: state_d = ST_NS_LO;
			ST_NS_LO:     state_d = ST_NS_HI_MUL;
			ST_NS_HI_MUL: state_d = ST_NS_HI;
			ST_NS_HI:     state_d = ST_DR_MUL;
			ST_DR_MUL:    state_d = ST_DR_SH;
			ST_DR_SH:     state_d = ST_DL_MUL;
			ST_DL_MUL:    state_d = ST_DL_LO;
			ST_DL_LO:     state_d = ST_DH_MUL;
			ST_DH_MUL:    state_d = ST_DH_HI;
			ST_DH_HI:     state_d = ST_SUM;
			ST_SUM:       state_d = ST_DONE;
			ST_DONE:      if (!out_valid_q || m_tready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
		if (seed_wr) begin
			state_d = ST_SEED;
		end
	end

	// Configuration, process value, generator position and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			theta_q     <= THETA_RST;
			mu_q        <= MEAN_RST;
			sigma_q     <= SIGMA_RST;
			x_q         <= START_RST;
			sat_q       <= 1'b0;
			seed_word_q <= SEED_RST;
			seed_idx_q  <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			res_val_q   <= '0;
			res_sat_q   <= 1'b0;
		end else begin
			// Seeding pass, one word a cycle.
			if (state_q == ST_SEED) begin
				seed_idx_q  <= seed_idx_q + MT_AW'(1);
				seed_word_q <= mt_seed_next(seed_word_q, seed_idx_q + MT_AW'(1));
			end
			if (state_q == ST_MT_WR) begin
				pos_q <= pos_next;
			end
			// Process value updates.
			if (in_accept && (s_tuser[0] == OP_LOAD)) begin
				x_q   <= s_tdata[62:31];
				sat_q <= 1'b0;
			end
			if (state_q == ST_SUM) begin
				x_q   <= sum_val;
				sat_q <= sum_sat;
			end
			// Output beat; the result register only changes when it is free.
			if (out_push) begin
				out_valid_q <= 1'b1;
				res_val_q   <= x_q;
				res_sat_q   <= sat_q;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			// Register writes.
			if (cfg_wr_en) begin
				unique case (cfg_addr)
					REG_THETA: theta_q <= cfg_wr_data[30:0];
					REG_MEAN:  mu_q    <= cfg_wr_data;
					REG_SIGMA: sigma_q <= cfg_wr_data[30:0];
					REG_SEED: begin
						seed_word_q <= cfg_wr_data;
						seed_idx_q  <= '0;
						pos_q       <= '0;
					end
					REG_START: x_q <= cfg_wr_data;
					default: ;
				endcase
			end
		end
	end

	// Arithmetic datapath.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				dt_q       <= s_tdata[30:0];
				diff_neg_q <= diff[32];
				adiff_q    <= diff[32] ? 32'(33'd0 - diff) : diff[31:0];
			end
			ST_MT_RD1: mt_w0_q <= ram_rdata;
			ST_MT_RD2: mt_w1_q <= ram_rdata;
			ST_MT_WR: begin
				neg_q <= ~mt_out[31];
				m_q   <= p_clamped;
				sh_q  <= '0;
				cnt_q <= '0;
			end
			ST_NORM: begin
				if (!m_q[31]) begin
					m_q  <= {m_q[30:0], 1'b0};
					sh_q <= sh_q + 5'd1;
				end
			end
			ST_LOG_ACC: begin
				cnt_q <= cnt_q + 6'd1;
				if (mm[32]) begin
					m_q <= mm[32:1];
					f_q <= {f_q[22:0], 1'b1};
				end else begin
					m_q <= mm[31:0];
					f_q <= {f_q[22:0], 1'b0};
				end
			end
			ST_Y_SET: begin
				sq_v_q   <= {10'd0, prod_q[59:30], 24'd0};
				sq_res_q <= '0;
				sq_bit_q <= 64'd1 << 62;
				sq_sel_q <= 1'b0;
			end
			ST_SQRT: begin
				sq_v_q   <= sq_v_next;
				sq_res_q <= sq_res_next;
				sq_bit_q <= sq_bit_q >> 2;
				if (sq_bit_q[0]) begin
					if (sq_sel_q) begin
						sdt_q <= sq_res_next[31:0];
					end else begin
						t_q <= sq_res_next[31:0];
					end
				end
			end
			// Numerator and denominator in Horner form.
			ST_N_ADD1: tmp_q <= prod_q[55:24] + C1;
			ST_N_ADD0: num_q <= 28'(prod_q[55:24] + C0);
			ST_D_ADD2: tmp_q <= prod_q[55:24] + D1;
			ST_D_ADD1: tmp_q <= prod_q[55:24] + D0;
			ST_D_ADD0: begin
				den_q <= prod_q[55:24] + ONE_Q24;
				dq_q  <= {num_q, 24'd0};
				rem_q <= '0;
				cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q <= div_ge ? div_r - den_q : div_r;
				dq_q  <= {dq_q[50:0], div_ge};
				cnt_q <= cnt_q + 6'd1;
			end
			ST_Z: begin
				zneg_q <= z_raw[32] ^ neg_q;
				az_q   <= z_raw[32] ? 32'(33'd0 - z_raw) : z_raw[31:0];
			end
			ST_SDT_SET: begin
				sq_v_q   <= {33'd0, dt_q} << FRAC_BITS;
				sq_res_q <= '0;
				sq_bit_q <= 64'd1 << 62;
				sq_sel_q <= 1'b1;
			end
			// Noise term.
			ST_S_SH:  s_q   <= prod_q >> FRAC_BITS;
			ST_NS_LO: acc_q <= {32'd0, prod_q};
			ST_NS_HI: noise_q <= cap_term(acc_sum >> 24);
			// Drift term.
			ST_DR_SH: a1_q  <= prod_q >> FRAC_BITS;
			ST_DL_LO: acc_q <= {32'd0, prod_q};
			ST_DH_HI: drift_q <= cap_term(acc_sum >> FRAC_BITS);
			default: ;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = res_val_q;
	assign m_tuser  = res_sat_q;

endmodule

FILE: hdl/ou_noise_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ou_noise_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ou_noise_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 624,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read; a read of the word being written returns its old value.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
